// ----- rtl/pngu_pkg.sv -----
package pngu_pkg;

  // column counter width, wraps at 16384
  localparam int COL_W = 14;
  localparam int PIX_BYTES = 4;
  localparam int MAX_ROW_BYTES_DEF = 8192;
  localparam logic [COL_W-1:0] ROW_BYTES_RESET = COL_W'(640);

  // filter type codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // one accepted byte on its way to reconstruction
  typedef struct packed {
    logic       is_data;
    logic [7:0] filt;
    logic       first_row;
    logic       last;
    logic [7:0] raw;
  } item_t;

  // paeth predictor on left, above and upper-left bytes
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

// ----- rtl/pngu_ram.sv -----
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pngu_seq.sv -----
module pngu_seq #(
  parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
  localparam int AW = $clog2(MAX_ROW_BYTES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pngu_pkg::COL_W-1:0]  cfg_data_i,
  input  logic                        acc_i,
  input  logic [7:0]                  raw_i,
  input  logic                        start_i,
  output pngu_pkg::item_t             item_o,
  output logic [AW-1:0]               addr_o
);

  localparam int LW = (AW + 1 > pngu_pkg::COL_W) ? AW + 1 : pngu_pkg::COL_W;
  localparam logic [LW-1:0] MAX_EXT = LW'(MAX_ROW_BYTES);

  logic [pngu_pkg::COL_W-1:0] row_bytes_q;
  logic [pngu_pkg::COL_W-1:0] column_q, column_d;
  logic                       awaiting_q, awaiting_d;
  logic                       first_row_q, first_row_d;
  logic [7:0]                 filt_q, filt_d;

  logic                       is_filter;
  logic [pngu_pkg::COL_W-1:0] col_inc;
  logic [LW-1:0]              col_ext;
  logic [LW-1:0]              len;
  logic                       last;

  // row length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= pngu_pkg::ROW_BYTES_RESET;
    end else if (cfg_we_i) begin
      row_bytes_q <= cfg_data_i;
    end
  end

  // row length in effect, clamped to one .. max
  always_comb begin
    if (row_bytes_q == '0) begin
      len = LW'(1);
    end else if (LW'(row_bytes_q) > MAX_EXT) begin
      len = MAX_EXT;
    end else begin
      len = LW'(row_bytes_q);
    end
  end

  // line store address and end of row
  assign col_ext   = LW'(column_q);
  assign addr_o    = (col_ext >= MAX_EXT) ? AW'(MAX_ROW_BYTES - 1) : AW'(column_q);
  assign col_inc   = column_q + 1'b1;
  assign last      = LW'(col_inc) >= len;
  assign is_filter = awaiting_q | start_i;

  // item handed to the reconstruction stage
  always_comb begin
    item_o.is_data   = !is_filter;
    item_o.filt      = is_filter ? raw_i : filt_q;
    item_o.first_row = first_row_q;
    item_o.last      = !is_filter && last;
    item_o.raw       = raw_i;
  end

  // row tracking next state
  always_comb begin
    column_d    = column_q;
    awaiting_d  = awaiting_q;
    first_row_d = first_row_q;
    filt_d      = filt_q;
    if (acc_i) begin
      if (is_filter) begin
        filt_d      = raw_i;
        awaiting_d  = 1'b0;
        column_d    = '0;
        first_row_d = start_i | first_row_q;
      end else if (last) begin
        column_d    = '0;
        awaiting_d  = 1'b1;
        first_row_d = 1'b0;
      end else begin
        column_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      awaiting_q  <= 1'b1;
      first_row_q <= 1'b1;
      filt_q      <= '0;
    end else begin
      column_q    <= column_d;
      awaiting_q  <= awaiting_d;
      first_row_q <= first_row_d;
      filt_q      <= filt_d;
    end
  end

endmodule

// ----- rtl/pngu_recon.sv -----
module pngu_recon #(
  parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
  localparam int AW = $clog2(MAX_ROW_BYTES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pngu_pkg::item_t item_i,
  input  logic [AW-1:0]   addr_i,
  output logic            acc_o,
  output logic            in_stall_o,
  input  logic [7:0]      ram_rdata_i,
  output logic            ram_we_o,
  output logic [AW-1:0]   ram_waddr_o,
  output logic [7:0]      ram_wdata_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      pixel_byte_o,
  output logic            row_last_o
);

  logic            s1_valid_q;
  pngu_pkg::item_t s1_item_q;
  logic [AW-1:0]   s1_addr_q;
  logic [31:0]     left_q;
  logic [31:0]     ul_q;
  logic            out_valid_q;
  logic [7:0]      pixel_q;
  logic            last_q;

  logic            out_free;
  logic            s1_adv;
  logic [7:0]      a, b, c;
  logic [8:0]      avg_sum;
  logic [7:0]      pred;
  logic [7:0]      pix;

  // handshake: s1 drains into the output register or retires a filter byte
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_item_q.is_data || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign acc_o      = in_valid_i && !in_stall_o;

  // stage 1 register, line store read is in flight alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_o) begin
      s1_item_q <= item_i;
      s1_addr_q <= addr_i;
    end
  end

  // neighbors and prediction
  assign a       = left_q[31:24];
  assign c       = ul_q[31:24];
  assign b       = s1_item_q.first_row ? 8'd0 : ram_rdata_i;
  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (s1_item_q.filt)
      pngu_pkg::FILT_SUB:   pred = a;
      pngu_pkg::FILT_UP:    pred = b;
      pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(a, b, c);
      default:              pred = 8'd0;
    endcase
  end

  assign pix = s1_item_q.raw + pred;

  // write back the reconstructed byte for the next row
  assign ram_we_o    = s1_adv && s1_item_q.is_data;
  assign ram_waddr_o = s1_addr_q;
  assign ram_wdata_o = pix;

  // left and upper-left byte history, cleared at each filter byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ul_q   <= '0;
    end else if (s1_adv) begin
      if (s1_item_q.is_data) begin
        left_q <= {left_q[23:0], pix};
        ul_q   <= {ul_q[23:0], b};
      end else begin
        left_q <= '0;
        ul_q   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ram_we_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we_o) begin
      pixel_q <= pix;
      last_q  <= s1_item_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_q;
  assign row_last_o   = last_q;

  // a held stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("stage 1 item lost while stalled");

  // a pending result is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // a new result only comes from a data byte leaving stage 1
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_item_q.is_data))
    else $error("result without a reconstructed byte");

  // nothing accepted into an occupied stage that does not drain
  a_acc_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_o |-> (!s1_valid_q || s1_adv))
    else $error("accept into a busy stage");

endmodule

// ----- rtl/png_scanline_unfilter_unit.sv -----
// a data byte reaches the output through the stage 1 register and the output register
// throughput: one byte per cycle, filter bytes included, while the output is not stalled;
//   the line store read is issued at accept and held for stage 1 to consume
// filter type bytes occupy one slot and give no result
// reset: asynchronous active low; row length 640, first row, awaiting filter
//   byte; the line store is not cleared
module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       row_bytes_we_i,
  input  logic [pngu_pkg::COL_W-1:0] row_bytes_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 raw_byte_i,
  input  logic                       image_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 pixel_byte_o,
  output logic                       row_last_o
);

  localparam int AW = $clog2(MAX_ROW_BYTES);

  pngu_pkg::item_t item;
  logic [AW-1:0]   raddr;
  logic            acc;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  // row tracking and line store addressing
  pngu_seq #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (row_bytes_we_i),
    .cfg_data_i (row_bytes_i),
    .acc_i      (acc),
    .raw_i      (raw_byte_i),
    .start_i    (image_start_i),
    .item_o     (item),
    .addr_o     (raddr)
  );

  // previous row line store
  pngu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc && item.is_data),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // reconstruction and output register
  pngu_recon #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_recon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .item_i       (item),
    .addr_i       (raddr),
    .acc_o        (acc),
    .in_stall_o   (in_stall_o),
    .ram_rdata_i  (ram_rdata),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_byte_o (pixel_byte_o),
    .row_last_o   (row_last_o)
  );

endmodule

// ----- verif/testbench.sv -----
module testbench;

  localparam int COL_W = pngu_pkg::COL_W;
  localparam int STORE_DEPTH = pngu_pkg::MAX_ROW_BYTES_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int MODE_QUOTA = 500;

  // one reconstructed channel byte as it should leave the block
  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } recon_byte_t;

  // tracks the unfilter state and the reconstructed bytes still owed by the block
  class unfilter_scoreboard;
    logic [7:0]       line_store [STORE_DEPTH];
    logic [31:0]      left_bytes;
    logic [31:0]      upleft_bytes;
    logic [COL_W-1:0] col;
    logic [7:0]       filter_type;
    bit               first_row;
    bit               awaiting_filter;
    logic [COL_W-1:0] row_bytes;
    recon_byte_t      owed_bytes [$];
    int               errors;
    int               bytes_in;
    int               bytes_out;
    int               rows_ended;

    function new();
      left_bytes      = '0;
      upleft_bytes    = '0;
      col             = '0;
      filter_type     = pngu_pkg::FILT_NONE;
      first_row       = 1'b1;
      awaiting_filter = 1'b1;
      row_bytes       = pngu_pkg::ROW_BYTES_RESET;
      errors          = 0;
      bytes_in        = 0;
      bytes_out       = 0;
      rows_ended      = 0;
    endfunction

    // row length in effect, clamped to the line store
    function int active_len();
      int n;
      n = int'(row_bytes);
      if (n < 1) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
    endfunction

    function void set_row_bytes(logic [COL_W-1:0] v);
      row_bytes = v;
    endfunction

    // paeth choice among left, above and upper-left
    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int pa;
      int pb;
      int pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    // update the unfilter state for one accepted input transaction
    function void note_input(logic [7:0] raw, logic start);
      int          x;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  pred;
      logic [7:0]  pix;
      recon_byte_t e;
      bytes_in++;
      if (start) begin
        first_row       = 1'b1;
        awaiting_filter = 1'b1;
      end
      // filter type byte opens a row and gives no output
      if (awaiting_filter) begin
        filter_type     = raw;
        awaiting_filter = 1'b0;
        col             = '0;
        left_bytes      = '0;
        upleft_bytes    = '0;
        return;
      end
      x = int'(col);
      if (x >= STORE_DEPTH) x = STORE_DEPTH - 1;
      a = left_bytes[31:24];
      b = first_row ? 8'h00 : line_store[x];
      c = upleft_bytes[31:24];
      case (filter_type)
        pngu_pkg::FILT_SUB:   pred = a;
        pngu_pkg::FILT_UP:    pred = b;
        pngu_pkg::FILT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
        pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
        default:              pred = 8'h00;
      endcase
      pix = raw + pred;
      line_store[x] = pix;
      left_bytes    = {left_bytes[23:0], pix};
      upleft_bytes  = {upleft_bytes[23:0], b};
      col    = col + 1'b1;
      e.pix  = pix;
      e.last = 1'b0;
      if (int'(col) >= active_len()) begin
        e.last          = 1'b1;
        col             = '0;
        first_row       = 1'b0;
        awaiting_filter = 1'b1;
      end
      owed_bytes.push_back(e);
    endfunction

    // compare one output transaction with the oldest owed byte
    function void check(logic [7:0] pix, logic last);
      recon_byte_t e;
      bytes_out++;
      if (owed_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: byte %h row_last %b", pix, last);
        return;
      end
      e = owed_bytes.pop_front();
      if (last) rows_ended++;
      if (e.pix !== pix || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch on output %0d: expected byte %h row_last %b, ",
                    "got byte %h row_last %b"},
                   bytes_out, e.pix, e.last, pix, last);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             row_bytes_we_i = 1'b0;
  logic [COL_W-1:0] row_bytes_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       raw_byte_i = '0;
  logic             image_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       pixel_byte_o;
  logic             row_last_o;

  unfilter_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rows_left = 0;
  bit force_start = 1'b0;
  int image_starts = 0;
  int reg_writes = 0;

  png_scanline_unfilter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_bytes_we_i (row_bytes_we_i),
    .row_bytes_i    (row_bytes_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_byte_i     (raw_byte_i),
    .image_start_i  (image_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_byte_o   (pixel_byte_o),
    .row_last_o     (row_last_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(pixel_byte_o, row_last_o);
  end

  // offer one byte, starting at a falling edge; returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] raw, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      raw_byte_i <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    raw_byte_i    <= raw;
    image_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(raw, start);
    @(negedge clk_i);
  endtask

  // let the block run empty before touching the register
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_row_bytes(input logic [COL_W-1:0] v);
    // a longer row would read line store bytes never written, so restart the image
    if (int'(v) > sb.active_len()) force_start = 1'b1;
    row_bytes_we_i <= 1'b1;
    row_bytes_i    <= v;
    @(negedge clk_i);
    row_bytes_we_i <= 1'b0;
    sb.set_row_bytes(v);
    reg_writes++;
  endtask

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(99) < 80)
      return 8'($urandom_range(pngu_pkg::FILT_NONE, pngu_pkg::FILT_PAETH));
    return 8'($urandom_range(pngu_pkg::FILT_PAETH + 1, 255));
  endfunction

  // mostly short rows, a few odd lengths
  function automatic logic [COL_W-1:0] pick_row_length();
    case ($urandom_range(9))
      0:       return COL_W'(4);
      1:       return COL_W'($urandom_range(5, 8));
      7:       return COL_W'($urandom_range(4, 40));
      8:       return COL_W'(4 * $urandom_range(17, 64));
      9:       return COL_W'($urandom_range(4, sb.active_len()));
      default: return COL_W'(4 * $urandom_range(1, 16));
    endcase
  endfunction

  // images of random rows; noise adds image starts in mid-row
  task automatic emit_stream(input int count, input bit noisy, input int rows_fixed);
    int         i;
    logic [7:0] raw;
    logic       start;
    for (i = 0; i < count; i++) begin
      start = force_start || (sb.awaiting_filter && rows_left == 0) ||
              (noisy && $urandom_range(99) < 2);
      if (start) begin
        force_start = 1'b0;
        image_starts++;
        rows_left = (rows_fixed > 0 ? rows_fixed : $urandom_range(1, 6)) - 1;
        raw = pick_filter();
      end else if (sb.awaiting_filter) begin
        rows_left--;
        raw = pick_filter();
      end else begin
        raw = 8'($urandom_range(255));
      end
      push_byte(raw, start);
    end
  endtask

  task automatic run_random_mode(input int mode);
    int sent;
    int n;
    sent = 0;
    while (sent < MODE_QUOTA) begin
      n = $urandom_range(20, 150);
      wait_idle();
      write_row_bytes(pick_row_length());
      if (mode == 2 && sent == 0) hold_requests++;
      emit_stream(n, 1'b1, 0);
      sent += n;
    end
  endtask

  // safety net against a hung handshake
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] pattern [5];
    logic [7:0] filters [4];
    int         r;
    int         k;
    sb = new();
    pattern = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    filters = '{pngu_pkg::FILT_SUB, pngu_pkg::FILT_PAETH, pngu_pkg::FILT_AVG,
                pngu_pkg::FILT_UP};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: Sub, Paeth, Avg and Up each on a five-byte row, then an unknown type cut short by a new image
    write_row_bytes(COL_W'(5));
    for (r = 0; r < 4; r++) begin
      push_byte(filters[r], r == 0);
      for (k = 0; k < 5; k++) push_byte(pattern[(k + r) % 5], 1'b0);
    end
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h09, 1'b1);
    push_byte(8'h80, 1'b0);
    image_starts += 3;

    // random: slow receiver, then slow sender, then full rate with one long receiver hold-off
    send_idle_pct = 29;
    recv_idle_pct = 81;
    run_random_mode(0);
    send_idle_pct = 81;
    recv_idle_pct = 29;
    run_random_mode(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_mode(2);

    in_valid_i <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    sb.errors += sb.owed_bytes.size();

    $display("run covered %0d input bytes, %0d checked output bytes, %0d completed rows",
             sb.bytes_in, sb.bytes_out, sb.rows_ended);
    $display("%0d image starts, %0d row length writes, %0d mismatches",
             image_starts, reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
